@@ rtl/kcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// kcpd_pkg
// Shared sizes, types and codes for the keyboard command prefix dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package kcpd_pkg;

    // table and line sizes
    localparam int LINE_MAX    = 64;
    localparam int ENTRY_MAX   = 16;
    localparam int COMMAND_MAX = 16;
    localparam int PID_COUNT   = 16;

    // derived widths
    localparam int LINE_IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int LINE_CNT_W = $clog2(LINE_MAX + 1);
    localparam int ENT_IDX_W  = (ENTRY_MAX > 1) ? $clog2(ENTRY_MAX) : 1;
    localparam int ENT_CNT_W  = $clog2(ENTRY_MAX + 1);
    localparam int CMD_IDX_W  = (COMMAND_MAX > 1) ? $clog2(COMMAND_MAX) : 1;
    localparam int CMD_LEN_W  = $clog2(COMMAND_MAX + 1);
    localparam int CMD_DEPTH  = ENTRY_MAX * COMMAND_MAX;
    localparam int CMD_ADDR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int PID_W      = $clog2(PID_COUNT);
    localparam int SENT_W     = 1 << PID_W;
    localparam int CHAR_W     = 8;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    // request types
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_KEY      = 1'b1;

    typedef logic [CHAR_W-1:0]     t_char;
    typedef logic [PID_W-1:0]      t_pid;
    typedef logic [LINE_IDX_W-1:0] t_line_idx;
    typedef logic [LINE_CNT_W-1:0] t_line_cnt;
    typedef logic [ENT_IDX_W-1:0]  t_ent_idx;
    typedef logic [ENT_CNT_W-1:0]  t_ent_cnt;
    typedef logic [CMD_IDX_W-1:0]  t_cmd_idx;
    typedef logic [CMD_LEN_W-1:0]  t_cmd_len;
    typedef logic [CMD_ADDR_W-1:0] t_cmd_addr;

    // one table entry: length and owner
    typedef struct packed {
        t_cmd_len len;
        t_pid     owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // memory port bundles from the sequencer
    typedef struct packed {
        logic      we;
        t_line_idx waddr;
        t_char     wdata;
        t_line_idx raddr;
    } t_line_port;

    typedef struct packed {
        logic      we;
        t_cmd_addr waddr;
        t_char     wdata;
        t_cmd_addr raddr;
    } t_cmd_port;

    typedef struct packed {
        logic     we;
        t_ent_idx waddr;
        t_entry   wdata;
        t_ent_idx raddr;
    } t_ent_port;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_COMPARE,
        ST_PUSH,
        ST_FINAL
    } t_state;

    // flat address of a character inside the command table
    function automatic t_cmd_addr cmd_addr(input t_ent_idx e, input t_cmd_idx k);
        t_cmd_addr base;
        base = t_cmd_addr'(e) * t_cmd_addr'(COMMAND_MAX);
        return base + t_cmd_addr'(k);
    endfunction

endpackage

`default_nettype wire

@@ rtl/kcpd_ram.sv @@
// ----------------------------------------------------------------------------
// kcpd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/kcpd_seq.sv @@
// ----------------------------------------------------------------------------
// kcpd_seq
// Line and table builder plus the dispatch sequencer: one character compare
// per cycle, walking the table in registration order.
// ----------------------------------------------------------------------------
`default_nettype none

module kcpd_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_req_type,
    input  wire kcpd_pkg::t_char      i_ch,
    input  wire kcpd_pkg::t_pid       i_pid,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output kcpd_pkg::t_pid            o_dest_pid,
    output kcpd_pkg::t_line_cnt       o_line_length,
    output logic                      o_last,
    output kcpd_pkg::t_line_port      o_line_port,
    input  wire kcpd_pkg::t_char      i_line_rdata,
    output kcpd_pkg::t_cmd_port       o_cmd_port,
    input  wire kcpd_pkg::t_char      i_cmd_rdata,
    output kcpd_pkg::t_ent_port       o_ent_port,
    input  wire kcpd_pkg::t_entry     i_ent_rdata
);

    import kcpd_pkg::*;

    t_state             r_state, n_state;
    t_line_cnt          r_line_count, n_line_count;
    t_ent_cnt           r_ent_total, n_ent_total;
    t_cmd_len           r_pending, n_pending;
    t_ent_idx           r_ent, n_ent;
    t_cmd_idx           r_k, n_k;
    t_cmd_len           r_len, n_len;
    t_pid               r_new_pid, n_new_pid;
    logic [SENT_W-1:0]  r_sent, n_sent;
    logic               r_hold_valid, n_hold_valid;
    t_pid               r_hold_pid, n_hold_pid;
    logic               r_out_valid, n_out_valid;
    t_pid               r_out_pid, n_out_pid;
    t_line_cnt          r_out_len, n_out_len;
    logic               r_out_last, n_out_last;

    logic               in_accept;
    logic               out_free;
    logic               ent_last;
    t_state             adv_state;
    t_ent_idx           adv_ent;
    t_ent_cnt           ent_next;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // move on to the next table entry or finish the walk
    assign ent_next  = t_ent_cnt'(r_ent) + t_ent_cnt'(1);
    assign ent_last  = (ent_next == r_ent_total);
    assign adv_state = ent_last ? ST_FINAL : ST_ENTRY;
    assign adv_ent   = ent_last ? r_ent : t_ent_idx'(ent_next);

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_line_count = r_line_count;
        n_ent_total  = r_ent_total;
        n_pending    = r_pending;
        n_ent        = r_ent;
        n_k          = r_k;
        n_len        = r_len;
        n_new_pid    = r_new_pid;
        n_sent       = r_sent;
        n_hold_valid = r_hold_valid;
        n_hold_pid   = r_hold_pid;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_pid    = r_out_pid;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;

        o_line_port.we    = 1'b0;
        o_line_port.waddr = t_line_idx'(r_line_count);
        o_line_port.wdata = i_ch;
        o_cmd_port.we     = 1'b0;
        o_cmd_port.waddr  = cmd_addr(t_ent_idx'(r_ent_total), t_cmd_idx'(r_pending));
        o_cmd_port.wdata  = i_ch;
        o_ent_port.we     = 1'b0;
        o_ent_port.waddr  = t_ent_idx'(r_ent_total);
        o_ent_port.wdata  = '{len: r_pending, owner: i_pid};

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_req_type == REQ_REGISTER) begin
                        // registration word: grow or close the pending entry
                        if (32'(r_ent_total) < ENTRY_MAX) begin
                            if (i_ch == CH_NUL) begin
                                o_ent_port.we = 1'b1;
                                n_ent_total   = r_ent_total + 1'b1;
                                n_pending     = '0;
                            end else if (32'(r_pending) < COMMAND_MAX) begin
                                o_cmd_port.we = 1'b1;
                                n_pending     = r_pending + 1'b1;
                            end
                        end
                    end else if (i_ch == CH_CR) begin
                        // line complete: start the table walk
                        n_sent       = '0;
                        n_hold_valid = 1'b0;
                        n_ent        = '0;
                        n_state      = (r_ent_total == '0) ? ST_FINAL : ST_ENTRY;
                    end else if (i_ch != CH_LF && i_ch != CH_NUL) begin
                        if (32'(r_line_count) < LINE_MAX) begin
                            o_line_port.we = 1'b1;
                            n_line_count   = r_line_count + 1'b1;
                        end
                    end
                end
            end

            ST_ENTRY: begin
                // entry header is on the read port
                n_len     = i_ent_rdata.len;
                n_new_pid = i_ent_rdata.owner;
                if (32'(i_ent_rdata.len) > 32'(r_line_count) ||
                    r_sent[i_ent_rdata.owner]) begin
                    n_state = adv_state;
                    n_ent   = adv_ent;
                end else if (i_ent_rdata.len == '0) begin
                    n_sent[i_ent_rdata.owner] = 1'b1;
                    n_state = ST_PUSH;
                end else begin
                    n_k     = '0;
                    n_state = ST_COMPARE;
                end
            end

            ST_COMPARE: begin
                // one character pair per cycle
                if (i_line_rdata != i_cmd_rdata) begin
                    n_state = adv_state;
                    n_ent   = adv_ent;
                end else if (32'(r_k) + 1 == 32'(r_len)) begin
                    n_sent[r_new_pid] = 1'b1;
                    n_state = ST_PUSH;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end

            ST_PUSH: begin
                // earlier match leaves as a non-final word
                if (!r_hold_valid) begin
                    n_hold_valid = 1'b1;
                    n_hold_pid   = r_new_pid;
                    n_state      = adv_state;
                    n_ent        = adv_ent;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pid   = r_hold_pid;
                    n_out_len   = r_line_count;
                    n_out_last  = 1'b0;
                    n_hold_pid  = r_new_pid;
                    n_state     = adv_state;
                    n_ent       = adv_ent;
                end
            end

            ST_FINAL: begin
                // last match leaves flagged, line cleared
                if (!r_hold_valid) begin
                    n_line_count = '0;
                    n_state      = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_pid    = r_hold_pid;
                    n_out_len    = r_line_count;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_line_count = '0;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // read addresses follow the next values so data lines up with r_k, r_ent
        o_line_port.raddr = t_line_idx'(n_k);
        o_cmd_port.raddr  = cmd_addr(n_ent, n_k);
        o_ent_port.raddr  = n_ent;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_ent_total  <= '0;
            r_pending    <= '0;
            r_sent       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_line_count <= n_line_count;
            r_ent_total  <= n_ent_total;
            r_pending    <= n_pending;
            r_sent       <= n_sent;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        r_ent      <= n_ent;
        r_k        <= n_k;
        r_len      <= n_len;
        r_new_pid  <= n_new_pid;
        r_hold_pid <= n_hold_pid;
        r_out_pid  <= n_out_pid;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_dest_pid    = r_out_pid;
    assign o_line_length = r_out_len;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

@@ rtl/keyboard_command_prefix_dispatch.sv @@
// A registration or keyboard word is taken and gives no result. A carriage return walks
// the table entry by entry: a header read, then the compared characters, then a push per
// match, with the one-character compare unit reading one line RAM and one command RAM
// location per cycle; a stalled output adds its wait.
// Throughput: one word at a time; the input stalls for the whole table walk.
// Reset: synchronous active low; counts, flags and sequencer clear, RAMs keep contents.
// ----------------------------------------------------------------------------
// keyboard_command_prefix_dispatch
// Builds a typed line and a table of registered command prefixes, and on
// carriage return sends the line length to every process whose prefix matches.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_command_prefix_dispatch (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_req_type,
    input  wire kcpd_pkg::t_char      i_ch,
    input  wire kcpd_pkg::t_pid       i_pid,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output kcpd_pkg::t_pid            o_dest_pid,
    output kcpd_pkg::t_line_cnt       o_line_length,
    output logic                      o_last
);

    import kcpd_pkg::*;

    t_line_port line_port;
    t_cmd_port  cmd_port;
    t_ent_port  ent_port;
    t_char      line_rdata;
    t_char      cmd_rdata;
    logic [ENTRY_W-1:0] ent_rdata;

    // sequencer and compare unit
    kcpd_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_ch          (i_ch),
        .i_pid         (i_pid),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_dest_pid    (o_dest_pid),
        .o_line_length (o_line_length),
        .o_last        (o_last),
        .o_line_port   (line_port),
        .i_line_rdata  (line_rdata),
        .o_cmd_port    (cmd_port),
        .i_cmd_rdata   (cmd_rdata),
        .o_ent_port    (ent_port),
        .i_ent_rdata   (t_entry'(ent_rdata))
    );

    // typed line characters
    kcpd_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_MAX)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_port.we),
        .i_waddr (line_port.waddr),
        .i_wdata (line_port.wdata),
        .i_raddr (line_port.raddr),
        .o_rdata (line_rdata)
    );

    // command characters, one row per entry
    kcpd_ram #(.WIDTH(CHAR_W), .DEPTH(CMD_DEPTH)) u_cmd_ram (
        .i_clk   (i_clk),
        .i_we    (cmd_port.we),
        .i_waddr (cmd_port.waddr),
        .i_wdata (cmd_port.wdata),
        .i_raddr (cmd_port.raddr),
        .o_rdata (cmd_rdata)
    );

    // entry length and owner
    kcpd_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRY_MAX)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_port.we),
        .i_waddr (ent_port.waddr),
        .i_wdata (ent_port.wdata),
        .i_raddr (ent_port.raddr),
        .o_rdata (ent_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/kcpd_checker.sv @@
// ----------------------------------------------------------------------------
// kcpd_checker
// Port level checks for the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kcpd_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 o_in_stall,
    input  wire logic                 i_req_type,
    input  wire kcpd_pkg::t_char      i_ch,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire kcpd_pkg::t_pid       o_dest_pid,
    input  wire kcpd_pkg::t_line_cnt  o_line_length,
    input  wire logic                 o_last
);

    import kcpd_pkg::*;

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_dest_pid) && $stable(o_line_length) && $stable(o_last))
        else $error("stalled result word changed");

    // a carriage return starts a walk that blocks input
    a_cr_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_req_type == REQ_KEY && i_ch == CH_CR |=> o_in_stall)
        else $error("input open after carriage return");

    // results only appear out of a table walk
    a_rise_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word outside a table walk");

endmodule

bind keyboard_command_prefix_dispatch kcpd_checker u_kcpd_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyboard command prefix dispatcher. Words go in
// from a backlog queue, and a behavioral copy of the command table and the line
// predicts every route. Both handshakes idle and stall at random, with long
// output hold-offs and drain pauses.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kcpd_pkg::*;

    // one input word waiting to be offered
    typedef struct {
        logic  kind;
        t_char ch;
        t_pid  pid;
        bit    drain_first;
    } t_kbd_word;

    // one expected delivery of a completed line
    typedef struct {
        t_pid      pid;
        t_line_cnt len;
        logic      last;
    } t_route;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    logic      i_req_type = REQ_KEY;
    t_char     i_ch = CH_NUL;
    t_pid      i_pid = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_pid      o_dest_pid;
    t_line_cnt o_line_length;
    logic      o_last;

    keyboard_command_prefix_dispatch DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_ch          (i_ch),
        .i_pid         (i_pid),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_dest_pid    (o_dest_pid),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the command table and the typed line
    t_char  line_buf [LINE_MAX];
    int     line_fill;
    t_char  tbl_text [ENTRY_MAX][COMMAND_MAX];
    int     tbl_len [ENTRY_MAX];
    t_pid   tbl_owner [ENTRY_MAX];
    int     table_used;
    int     text_fill;
    t_route due_routes[$];

    // stimulus side: backlog and what the generator has registered so far
    t_kbd_word word_backlog[$];
    t_char     gen_text [ENTRY_MAX][COMMAND_MAX];
    int        gen_len [ENTRY_MAX];
    int        gen_entries;
    int        useful_words;
    bit        drain_next;

    // handshake bookkeeping
    t_kbd_word cur_word;
    bit        offering;
    int        tx_gap;
    bit        tx_calm;
    int        words_offered;
    int        words_taken;
    int        results_seen;
    int        results_acked;
    int        rx_wait;
    int        rx_hold;
    int        hold_mark = 20;
    bit        rx_calm;
    int        failures;

    // update the mirror with one accepted word and queue the routes it causes
    task automatic route_word(input logic kind, input t_char ch, input t_pid pid);
        bit [PID_COUNT-1:0] told;
        t_pid               hits[$];
        t_route             r;
        bit                 same;
        if (kind == REQ_REGISTER) begin
            if (table_used < ENTRY_MAX) begin
                if (ch == CH_NUL) begin
                    tbl_len[table_used] = text_fill;
                    tbl_owner[table_used] = pid;
                    table_used++;
                    text_fill = 0;
                end else if (text_fill < COMMAND_MAX) begin
                    tbl_text[table_used][text_fill] = ch;
                    text_fill++;
                end
            end
        end else if (ch == CH_CR) begin
            // walk entries in registration order, each owner once
            told = '0;
            for (int e = 0; e < table_used; e++) begin
                same = (tbl_len[e] <= line_fill);
                for (int k = 0; k < tbl_len[e] && same; k++)
                    same = (line_buf[k] == tbl_text[e][k]);
                if (same && !told[tbl_owner[e]]) begin
                    told[tbl_owner[e]] = 1'b1;
                    hits.push_back(tbl_owner[e]);
                end
            end
            foreach (hits[i]) begin
                r.pid  = hits[i];
                r.len  = t_line_cnt'(line_fill);
                r.last = (i == hits.size() - 1);
                due_routes.push_back(r);
            end
            line_fill = 0;
        end else if (ch != CH_LF && ch != CH_NUL && line_fill < LINE_MAX) begin
            line_buf[line_fill] = ch;
            line_fill++;
        end
    endtask

    // mostly a small alphabet so that lines hit registered prefixes
    function automatic t_char pick_char();
        if ($urandom_range(0, 4) != 0)
            return t_char'(8'h61 + $urandom_range(0, 3));
        return t_char'($urandom_range(1, 255));
    endfunction

    task automatic push_word(input logic kind, input t_char ch, input t_pid pid);
        t_kbd_word w;
        w.kind        = kind;
        w.ch          = ch;
        w.pid         = pid;
        w.drain_first = drain_next;
        drain_next    = 1'b0;
        word_backlog.push_back(w);
        // ignored words do not count toward the stimulus length
        if (kind == REQ_KEY ? (ch != CH_LF && ch != CH_NUL) : (gen_entries < ENTRY_MAX))
            useful_words++;
    endtask

    // command characters carry random pids, the terminating NUL the owner
    task automatic queue_command(input t_char text[$], input t_pid owner);
        foreach (text[k])
            push_word(REQ_REGISTER, text[k], t_pid'($urandom_range(0, PID_COUNT - 1)));
        push_word(REQ_REGISTER, CH_NUL, owner);
        if (gen_entries < ENTRY_MAX) begin
            gen_len[gen_entries] = (text.size() < COMMAND_MAX) ? text.size() : COMMAND_MAX;
            for (int k = 0; k < gen_len[gen_entries]; k++)
                gen_text[gen_entries][k] = text[k];
            gen_entries++;
        end
    endtask

    // input driver: draws a gap per word, holds the payload while stalled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (offering && words_taken == words_offered) begin
                offering = 1'b0;
                if (words_offered % 40 == 0)
                    tx_calm = ($urandom_range(0, 3) == 0);
                tx_gap = tx_calm ? 0 : $urandom_range(0, 6);
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (word_backlog.size() != 0 &&
                             !(word_backlog[0].drain_first && due_routes.size() != 0)) begin
                    cur_word = word_backlog.pop_front();
                    offering = 1'b1;
                    words_offered++;
                    i_req_type <= cur_word.kind;
                    i_ch       <= cur_word.ch;
                    i_pid      <= cur_word.pid;
                end
            end
            i_in_valid <= offering;
        end
    end

    // output receiver: short random stalls, now and then a long hold-off
    always @(negedge i_clk) begin
        if (results_acked != results_seen) begin
            results_acked = results_seen;
            if (results_seen % 40 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
        end
        if (rx_hold == 0 && o_out_valid && results_seen >= hold_mark) begin
            rx_hold = 400;
            hold_mark += 150;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: check each delivered word, then feed accepted input to the mirror
    always @(posedge i_clk) begin
        t_route want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (due_routes.size() == 0) begin
                    $error("dest_pid: expected none, actual %0d", o_dest_pid);
                    failures++;
                end else begin
                    want = due_routes.pop_front();
                    if (o_dest_pid !== want.pid) begin
                        $error("dest_pid: expected %0d, actual %0d", want.pid, o_dest_pid);
                        failures++;
                    end
                    if (o_line_length !== want.len) begin
                        $error("line_length: expected %0d, actual %0d",
                               want.len, o_line_length);
                        failures++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_last);
                        failures++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                words_taken++;
                route_word(i_req_type, i_ch, i_pid);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        t_char text[$];
        int    mode;
        int    n;
        int    e;
        int    seq_count;

        // typed newline and NUL are dropped, and an empty table routes nothing
        push_word(REQ_KEY, 8'h78, t_pid'($urandom));
        push_word(REQ_KEY, CH_LF, 4'd0);
        push_word(REQ_KEY, CH_NUL, 4'd15);
        push_word(REQ_KEY, CH_CR, t_pid'($urandom));
        // over-long command with extreme bytes, owned by the NUL's pid
        text = '{8'hFF, 8'h01, 8'h80, 8'h7F};
        repeat (13) text.push_back(pick_char());
        queue_command(text, 4'd0);
        // empty command matches every line, even an empty one
        text = {};
        queue_command(text, 4'd15);
        push_word(REQ_KEY, CH_CR, t_pid'($urandom));

        // random sequences: about half registrations until the table fills, then mostly lines
        while (useful_words < 430) begin
            seq_count++;
            if (seq_count % 15 == 0)
                drain_next = 1'b1;
            text = {};
            if ($urandom_range(0, (gen_entries < ENTRY_MAX) ? 1 : 11) == 0) begin
                mode = $urandom_range(0, 9);
                n = (mode < 7) ? $urandom_range(1, 3) :
                    (mode < 9) ? $urandom_range(4, 8) : $urandom_range(17, 20);
                repeat (n) text.push_back(pick_char());
                queue_command(text, t_pid'($urandom_range(0, PID_COUNT - 1)));
            end else begin
                mode = $urandom_range(0, 19);
                if (mode < 13 && gen_entries > 0) begin
                    // a registered prefix, sometimes cut short or corrupted
                    e = $urandom_range(0, gen_entries - 1);
                    for (int k = 0; k < gen_len[e]; k++)
                        text.push_back(gen_text[e][k]);
                    if (text.size() != 0 && $urandom_range(0, 4) == 0)
                        void'(text.pop_back());
                    else if (text.size() != 0 && $urandom_range(0, 5) == 0)
                        text[$urandom_range(0, text.size() - 1)] = pick_char();
                    repeat ($urandom_range(0, 4)) text.push_back(pick_char());
                end else if (mode < 15) begin
                    repeat ($urandom_range(0, 10)) text.push_back(t_char'($urandom_range(0, 255)));
                end else if (mode < 17) begin
                    // often runs past the line limit
                    repeat ($urandom_range(60, 75)) text.push_back(pick_char());
                end else begin
                    repeat ($urandom_range(0, 5)) text.push_back(pick_char());
                end
                foreach (text[k]) begin
                    push_word(REQ_KEY, text[k], t_pid'($urandom));
                    if ($urandom_range(0, 19) == 0)
                        push_word(REQ_KEY, $urandom_range(0, 1) ? CH_LF : CH_NUL,
                                  t_pid'($urandom));
                end
                push_word(REQ_KEY, CH_CR, t_pid'($urandom));
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_backlog.size() != 0 || words_taken != words_offered)
            @(posedge i_clk);
        while (due_routes.size() != 0)
            @(posedge i_clk);
        // a last carriage return with no match may still be walking the table
        repeat (300) @(posedge i_clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
